// ===== design/ras_pkg.sv =====
// ras_pkg: shared widths, types and state codes for the rational add/subtract block
// no dependencies; used by ras_div and rational_add_subtract
package ras_pkg;

  // operand width of each numerator and denominator
  localparam int OPW = 16;

  // fixed output field widths
  localparam int NUM_W = 33;
  localparam int DEN_W = 31;

  // product, sum and divider widths
  localparam int PROD_W = 2 * OPW;
  localparam int DW     = PROD_W + 1;
  localparam int CNT_W  = $clog2(DW + 1);

  // widths used when wrapping quotients into the output fields
  localparam int NUM_EXT_W = (DW > NUM_W) ? DW : NUM_W;
  localparam int DEN_EXT_W = (DW > DEN_W) ? DW : DEN_W;

  // stream widths
  localparam int IN_DATA_W  = ((4 * OPW + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((NUM_W + DEN_W + 7) / 8) * 8;

  // status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_ZERO_DEN = 1'b1;

  // operation codes
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;

  // divider request and response
  typedef struct packed {
    logic start;
    logic wide;   // full dividend width, else operand width only
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GCD_GO,
    ST_GCD_RUN,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_COMBINE,
    ST_DIVN_GO,
    ST_DIVN_RUN,
    ST_DIVD_GO,
    ST_DIVD_RUN,
    ST_FINISH
  } state_t;

endpackage

// ===== design/ras_div.sv =====
// ras_div: shared restoring divider, one quotient bit per cycle
// depends on ras_pkg for widths and the request/response structs
module ras_div
  import ras_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  div_req_t       req,
  input  logic [DW-1:0]  dividend,
  input  logic [OPW-1:0] divisor,
  output div_rsp_t       rsp,
  output logic [DW-1:0]  quotient,
  output logic [OPW-1:0] remainder
);

  logic [OPW:0]     rem;
  logic [DW-1:0]    quo;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [OPW:0]     shifted;
  logic             ge;
  logic [OPW:0]     diff;

  // one restoring step
  always_comb begin
    shifted = {rem[OPW-1:0], quo[DW-1]};
    ge      = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= req.wide ? CNT_W'(DW) : CNT_W'(OPW);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: narrow requests sit at the top of the shift register
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem <= '0;
      quo <= req.wide ? dividend : {dividend[OPW-1:0], {(DW-OPW){1'b0}}};
    end else if (busy) begin
      rem <= ge ? diff : shifted;
      quo <= {quo[DW-2:0], ge};
    end
  end

  assign rsp.busy  = busy;
  assign rsp.done  = done;
  assign quotient  = quo;
  assign remainder = rem[OPW-1:0];

  // remainder is reduced below the divisor at the end of a run
  a_rem_below: assert property (@(posedge clk) disable iff (rst)
    done && divisor != '0 |-> {1'b0, rem[OPW-1:0]} < {1'b0, divisor} && !rem[OPW])
    else $error("divider remainder not reduced");

  // a running divider always has steps left
  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != '0)
    else $error("divider busy with zero count");

  // done only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("divider done without a run");

endmodule

// ===== design/rational_add_subtract.sv =====
// rational_add_subtract: top level, sequencer, shared multiplier and output register
// depends on ras_pkg and ras_div
//
// Adds (tuser 0) or subtracts (tuser 1) two fractions and returns the result over
// den_a*den_b/gcd, not fully reduced. A zero denominator returns status 1 with zero
// fields. Otherwise the sequencer finds the gcd of the denominators by Euclid
// remainder steps, forms both cross products and den_a*den_b on the shared
// multiplier, combines them and divides numerator and denominator by the gcd.
// The shared one-bit-per-cycle divider is used for every Euclid remainder and
// for both final divisions. The next request is taken while a finished result
// still waits in the output register.
module rational_add_subtract
  import ras_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // num_a, den_a, num_b, den_b
  input  logic [0:0]            s_axis_tuser,  // operation
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // result_num, result_den
  output logic [0:0]            m_axis_tuser   // status
);

  // magnitude of a two's complement operand
  function automatic logic [OPW-1:0] mag_of(input logic [OPW-1:0] v);
    mag_of = v[OPW-1] ? (~v + OPW'(1)) : v;
  endfunction

  state_t state, state_next;

  logic [OPW-1:0]    na, da, nb, db;
  logic              s1, s2;
  logic              err;
  logic [OPW-1:0]    gx, gy, gval;
  logic [PROD_W-1:0] t1, t2, pden;
  logic [DW-1:0]     mag;
  logic              neg;
  logic [DW-1:0]     qnum;
  logic              out_valid;
  logic [NUM_W-1:0]  out_num;
  logic [DEN_W-1:0]  out_den;
  logic              out_status;

  logic [OPW-1:0]    in_num_a, in_den_a, in_num_b, in_den_b;
  logic              in_op;
  logic              accept;
  logic              out_free;

  logic [OPW-1:0]    mul_x, mul_y;
  logic [PROD_W-1:0] product;
  logic [DW-1:0]     sum_same, sum_diff;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic [DW-1:0]     div_dividend;
  logic [OPW-1:0]    div_divisor;
  logic [DW-1:0]     div_quo;
  logic [OPW-1:0]    div_rem;

  logic [NUM_EXT_W-1:0] num_ext, num_signed;
  logic [DEN_EXT_W-1:0] den_ext;

  // request fields
  assign in_num_a = s_axis_tdata[OPW-1:0];
  assign in_den_a = s_axis_tdata[2*OPW-1:OPW];
  assign in_num_b = s_axis_tdata[3*OPW-1:2*OPW];
  assign in_den_b = s_axis_tdata[4*OPW-1:3*OPW];
  assign in_op    = s_axis_tuser[0];

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;

  // shared multiplier, operands picked by state
  always_comb begin
    case (state)
      ST_MUL_A: begin mul_x = na; mul_y = db; end
      ST_MUL_B: begin mul_x = nb; mul_y = da; end
      default:  begin mul_x = da; mul_y = db; end
    endcase
    product = PROD_W'(mul_x) * PROD_W'(mul_y);
  end

  // signed sum of the cross products as sign and magnitude
  assign sum_same = {1'b0, t1} + {1'b0, t2};
  assign sum_diff = (t1 >= t2) ? DW'(t1 - t2) : DW'(t2 - t1);

  // divider operands
  always_comb begin
    div_req.start = 1'b0;
    div_req.wide  = 1'b1;
    div_dividend  = DW'(pden);
    div_divisor   = gval;
    case (state)
      ST_GCD_GO: begin
        div_req.start = 1'b1;
        div_req.wide  = 1'b0;
        div_dividend  = DW'(gx);
        div_divisor   = gy;
      end
      ST_GCD_RUN: begin
        div_req.wide  = 1'b0;
        div_dividend  = DW'(gx);
        div_divisor   = gy;
      end
      ST_DIVN_GO: begin
        div_req.start = 1'b1;
        div_dividend  = mag;
      end
      ST_DIVN_RUN: div_dividend = mag;
      ST_DIVD_GO: div_req.start = 1'b1;
      default: ;
    endcase
  end

  ras_div u_div (
    .clk       (clk),
    .rst       (rst),
    .req       (div_req),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .rsp       (div_rsp),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_den_a == '0 || in_den_b == '0) state_next = ST_FINISH;
          else                                  state_next = ST_GCD_GO;
        end
      end
      ST_GCD_GO:  state_next = ST_GCD_RUN;
      ST_GCD_RUN: begin
        if (div_rsp.done) state_next = (div_rem == '0) ? ST_MUL_A : ST_GCD_GO;
      end
      ST_MUL_A:    state_next = ST_MUL_B;
      ST_MUL_B:    state_next = ST_MUL_C;
      ST_MUL_C:    state_next = ST_COMBINE;
      ST_COMBINE:  state_next = ST_DIVN_GO;
      ST_DIVN_GO:  state_next = ST_DIVN_RUN;
      ST_DIVN_RUN: if (div_rsp.done) state_next = ST_DIVD_GO;
      ST_DIVD_GO:  state_next = ST_DIVD_RUN;
      ST_DIVD_RUN: if (div_rsp.done) state_next = ST_FINISH;
      ST_FINISH:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // operand capture, euclid registers, products, signed sum and numerator quotient
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          na  <= mag_of(in_num_a);
          da  <= mag_of(in_den_a);
          nb  <= mag_of(in_num_b);
          db  <= mag_of(in_den_b);
          gx  <= mag_of(in_den_a);
          gy  <= mag_of(in_den_b);
          s1  <= in_num_a[OPW-1] ^ in_den_a[OPW-1];
          s2  <= in_num_b[OPW-1] ^ in_den_b[OPW-1] ^ (in_op == OP_SUB);
          err <= (in_den_a == '0 || in_den_b == '0);
        end
      end
      ST_GCD_RUN: begin
        if (div_rsp.done) begin
          if (div_rem == '0) begin
            gval <= gy;
          end else begin
            gx <= gy;
            gy <= div_rem;
          end
        end
      end
      ST_MUL_A: t1   <= product;
      ST_MUL_B: t2   <= product;
      ST_MUL_C: pden <= product;
      ST_COMBINE: begin
        if (s1 == s2) begin
          mag <= sum_same;
          neg <= s1;
        end else begin
          mag <= sum_diff;
          neg <= (t1 >= t2) ? s1 : s2;
        end
      end
      ST_DIVN_RUN: if (div_rsp.done) qnum <= div_quo;
      default: ;
    endcase
  end

  // final sign and wrap into the output widths
  assign num_ext    = NUM_EXT_W'(qnum);
  assign num_signed = (neg && qnum != '0) ? (~num_ext + NUM_EXT_W'(1)) : num_ext;
  assign den_ext    = DEN_EXT_W'(div_quo);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // result fields, loaded only when the output register is free
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      out_num    <= err ? '0 : num_signed[NUM_W-1:0];
      out_den    <= err ? '0 : den_ext[DEN_W-1:0];
      out_status <= err ? STATUS_ZERO_DEN : STATUS_OK;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = OUT_DATA_W'({out_den, out_num});
  assign m_axis_tuser[0] = out_status;

  // a zero denominator skips straight to the result
  a_zero_den_short: assert property (@(posedge clk) disable iff (rst)
    accept && (in_den_a == '0 || in_den_b == '0) |=> state == ST_FINISH && err)
    else $error("zero denominator not short-cut");

  // an error result carries zero fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == STATUS_ZERO_DEN |-> out_num == '0 && out_den == '0)
    else $error("error result with nonzero fields");

  // the gcd used for the final divisions is never zero
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVN_GO |-> gval != '0)
    else $error("zero gcd reached division");

  // a pending result is not overwritten before it is taken
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_axis_tready |=> out_valid && $stable(out_num) && $stable(out_den)
      && $stable(out_status))
    else $error("pending result lost");

endmodule
